>>> hw/rtl/dlwpm_pkg.sv
// dlwpm_pkg: shared widths, register indexes, setting codes and types
// for the dual layer window priority mixer; no dependencies
package dlwpm_pkg;

  // field widths
  localparam int COL_W   = 10;
  localparam int PIX_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int CFG_W   = 16;
  localparam int IDX_W   = 3;

  // flag bits inside a layer pixel word
  localparam int SPRITE_FLAG_BIT      = 13;
  localparam int TRANSPARENT_FLAG_BIT = 14;

  // a window edge sits this many pixels left of its register value
  localparam logic [COL_W:0] WIN_OFFSET = (COL_W + 1)'(16);

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_PRIORITY_A   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRIORITY_B   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW1_POS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW2_POS  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BACKGROUND   = 3'd4;

  // register reset values
  localparam logic [PRIO_W-1:0] PRIORITY_RESET = 8'h11;

  // region codes: {inside window 2, inside window 1}
  localparam logic [1:0] REGION_OUTSIDE = 2'b00;
  localparam logic [1:0] REGION_W1_ONLY = 2'b01;
  localparam logic [1:0] REGION_W2_ONLY = 2'b10;
  localparam logic [1:0] REGION_BOTH    = 2'b11;

  // layer enable codes (setting bits 1:0)
  localparam logic [1:0] LAYER_NONE = 2'b00;
  localparam logic [1:0] LAYER_1    = 2'b01;
  localparam logic [1:0] LAYER_2    = 2'b10;
  localparam logic [1:0] LAYER_BOTH = 2'b11;

  // priority modes (setting bits 3:2); the other two codes are plain transparency
  localparam logic [1:0] MODE_SPR2_OVER  = 2'd1;
  localparam logic [1:0] MODE_SPR1_UNDER = 2'd2;

  // live configuration, handed from the register file to the mixer
  typedef struct packed {
    logic [PRIO_W-1:0] priority_a;
    logic [PRIO_W-1:0] priority_b;
    logic [COL_W-1:0]  window1_pos;
    logic [COL_W-1:0]  window2_pos;
    logic [PIX_W-1:0]  background_color;
  } cfg_t;

endpackage

>>> hw/rtl/dlwpm_in_if.sv
// dlwpm_in_if: input channel carrying column and both layer pixel words
// depends on dlwpm_pkg
interface dlwpm_in_if
  import dlwpm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [PIX_W-1:0] layer1_pixel;
  logic [PIX_W-1:0] layer2_pixel;

  modport source (output valid, output column, output layer1_pixel,
                  output layer2_pixel, input ready);
  modport sink   (input valid, input column, input layer1_pixel,
                  input layer2_pixel, output ready);
endinterface

>>> hw/rtl/dlwpm_out_if.sv
// dlwpm_out_if: output channel carrying the merged color
// depends on dlwpm_pkg
interface dlwpm_out_if
  import dlwpm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

>>> hw/rtl/dual_layer_window_priority_mixer.sv
// dual_layer_window_priority_mixer: top level, input register, mixer, result register
// depends on dlwpm_pkg, dlwpm_in_if, dlwpm_out_if, dlwpm_cfg, dlwpm_mix
//
// usage
// - px_in carries one item per handshake: column index and the pixel words
//   of both layer generators; mix_out returns one merged color per item
// - cfg_we / cfg_index / cfg_data write the five setting registers
//   (priority_a, priority_b, window1_pos, window2_pos, background_color);
//   write them only while no item is in flight
// - from input handshake to the color on mix_out:
//   the item lands in the input register, passes the window and priority
//   select logic, and lands in the result register
// - throughput is one item per cycle while mix_out.ready is high; both stages
//   advance together; the input stage refills in the same cycle the result stage drains
// - when the receiver stalls, the result register holds its color, the
//   input register still takes one more item, and px_in.ready drops once
//   both stages are full
// - reset (rst, synchronous) empties both stages and loads the register
//   reset values: both priority registers 0x11, windows and background 0
module dual_layer_window_priority_mixer
  import dlwpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  dlwpm_in_if.sink         px_in,
  dlwpm_out_if.source      mix_out
);

  cfg_t             cfg;
  logic             s0_valid;
  logic [COL_W-1:0] s0_column;
  logic [PIX_W-1:0] s0_layer1;
  logic [PIX_W-1:0] s0_layer2;
  logic             s1_valid;
  logic [PIX_W-1:0] s1_color;
  logic [PIX_W-1:0] color_next;
  logic             s1_load;
  logic             s0_load;

  dlwpm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dlwpm_mix u_mix (
    .cfg          (cfg),
    .column       (s0_column),
    .layer1_pixel (s0_layer1),
    .layer2_pixel (s0_layer2),
    .color        (color_next)
  );

  // stage handshakes
  assign s1_load     = s0_valid && (!s1_valid || mix_out.ready);
  assign px_in.ready = !s0_valid || s1_load;
  assign s0_load     = px_in.valid && px_in.ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (px_in.ready) begin
      s0_valid <= px_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_load) begin
      s0_column <= px_in.column;
      s0_layer1 <= px_in.layer1_pixel;
      s0_layer2 <= px_in.layer2_pixel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || mix_out.ready) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_color <= color_next;
    end
  end

  assign mix_out.valid = s1_valid;
  assign mix_out.color = s1_color;

  // an accepted item sits in the input register next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    s0_load |=> s0_valid)
    else $error("accepted item missing from input register");

  // an empty input register never refuses an item
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s0_valid |-> px_in.ready)
    else $error("input stalled with empty input register");

  // an item moved forward shows up on the output with its mixed color
  a_forward: assert property (@(posedge clk) disable iff (rst)
    s1_load |=> (mix_out.valid && mix_out.color == $past(color_next)))
    else $error("result register lost a forwarded item");

  // a priority_a write lands in the register file
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == REG_PRIORITY_A) |=>
      cfg.priority_a == $past(cfg_data[PRIO_W-1:0]))
    else $error("priority_a write not taken");

endmodule

>>> hw/rtl/dlwpm_cfg.sv
// dlwpm_cfg: configuration register file written through a plain write port
// depends on dlwpm_pkg
module dlwpm_cfg
  import dlwpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output cfg_t             cfg
);

  cfg_t regs;

  // register writes, unused indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.priority_a       <= PRIORITY_RESET;
      regs.priority_b       <= PRIORITY_RESET;
      regs.window1_pos      <= '0;
      regs.window2_pos      <= '0;
      regs.background_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRIORITY_A:  regs.priority_a       <= cfg_data[PRIO_W-1:0];
        REG_PRIORITY_B:  regs.priority_b       <= cfg_data[PRIO_W-1:0];
        REG_WINDOW1_POS: regs.window1_pos      <= cfg_data[COL_W-1:0];
        REG_WINDOW2_POS: regs.window2_pos      <= cfg_data[COL_W-1:0];
        REG_BACKGROUND:  regs.background_color <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

>>> hw/rtl/dlwpm_mix.sv
// dlwpm_mix: window region decode and layer priority select for one item
// depends on dlwpm_pkg
module dlwpm_mix
  import dlwpm_pkg::*;
(
  input  cfg_t             cfg,
  input  logic [COL_W-1:0] column,
  input  logic [PIX_W-1:0] layer1_pixel,
  input  logic [PIX_W-1:0] layer2_pixel,
  output logic [PIX_W-1:0] color
);

  logic       in_win1;
  logic       in_win2;
  logic [3:0] setting;
  logic [1:0] enable;
  logic [1:0] mode;
  logic       s1, s2, t1, t2;
  logic       pick2;

  // column < pos - 16 (clamped at 0) is column + 16 < pos
  assign in_win1 = ({1'b0, column} + WIN_OFFSET) < {1'b0, cfg.window1_pos};
  assign in_win2 = ({1'b0, column} + WIN_OFFSET) < {1'b0, cfg.window2_pos};

  // region setting lookup
  always_comb begin
    unique case ({in_win2, in_win1})
      REGION_BOTH:    setting = cfg.priority_a[3:0];
      REGION_W2_ONLY: setting = cfg.priority_a[7:4];
      REGION_W1_ONLY: setting = cfg.priority_b[3:0];
      default:        setting = cfg.priority_b[7:4];
    endcase
  end

  assign enable = setting[1:0];
  assign mode   = setting[3:2];

  assign s1 = layer1_pixel[SPRITE_FLAG_BIT];
  assign s2 = layer2_pixel[SPRITE_FLAG_BIT];
  assign t1 = layer1_pixel[TRANSPARENT_FLAG_BIT];
  assign t2 = layer2_pixel[TRANSPARENT_FLAG_BIT];

  // priority between the two layers when both are on
  always_comb begin
    unique case (mode)
      MODE_SPR2_OVER:  pick2 = t1 || (s2 && !s1);
      MODE_SPR1_UNDER: pick2 = t1 || (s1 && !s2 && !t2);
      default:         pick2 = t1;
    endcase
  end

  // final color select
  always_comb begin
    unique case (enable)
      LAYER_NONE: color = cfg.background_color;
      LAYER_1:    color = layer1_pixel;
      LAYER_2:    color = layer2_pixel;
      default:    color = pick2 ? layer2_pixel : layer1_pixel;
    endcase
  end

endmodule
